// File: hdl/nfhia_pkg.sv
`default_nettype none

package nfhia_pkg;

    localparam int ID_WIDTH    = 16;
    localparam int FIELD_W     = 16;
    localparam int ALL_ONES_ID = (1 << ID_WIDTH) - 1;
    localparam int WORD_BITS   = (ID_WIDTH >= 7) ? 5 : ID_WIDTH - 2;
    localparam int WORD_W      = 1 << WORD_BITS;
    localparam int ADDR_W      = ID_WIDTH - WORD_BITS;
    localparam int NUM_WORDS   = 1 << ADDR_W;
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] given_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] result_id;
    } rsp_t;

    function automatic logic id_valid(input logic [FIELD_W-1:0] id);
        return (id != '0) && (id < FIELD_W'(ALL_ONES_ID));
    endfunction

    // lowest set bit
    function automatic logic [WORD_BITS-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [WORD_BITS-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = WORD_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hdl/next_fit_handle_id_allocator_top.sv
// Next-fit handle id allocator.
// Command channel: a transfer happens on a clock edge with start high and
// busy low; cmd carries op (allocate, free, query) and given_id.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall it, so every result must be taken in that cycle.
// The in-use map is a single-port memory of 32-bit words, one read or one
// write per cycle, with registered read data.
// Free and query: busy in the check state, after the word is read; check and write
// back happen at the end of it, and done rises as busy drops, so a new
// command may be issued in the done cycle.
// Allocate: busy while the scan reads word after word until one holds a free id;
// the scan starts at the rotating pointer and wraps, reading every word once
// and the start word a second time at most.
// A full map returns status full with id 0.
// Reset: busy stays high for NUM_WORDS cycles (2048) while a clearing pass
// zeroes the map one word per cycle; the pointer resets to 1.
`default_nettype none

module next_fit_handle_id_allocator_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  nfhia_pkg::cmd_t    cmd,
    output logic               done,
    output nfhia_pkg::rsp_t    rsp
);
    import nfhia_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_CHECK = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] off_reg, off_next;
    logic                 first_reg, first_next;
    logic [1:0]           op_reg, op_next;
    logic [FIELD_W-1:0]   gid_reg, gid_next;
    logic [FIELD_W-1:0]   search_start_reg, search_start_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [WORD_W-1:0]    mem_rdata_reg;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_addr;
    logic [WORD_W-1:0]    mem_wdata;

    logic [ID_WIDTH-1:0]  cand;
    logic [WORD_W-1:0]    start_mask, valid_mask, free_vec;
    logic [WORD_BITS-1:0] hit_idx;
    logic                 hit;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        start_mask = first_reg ? ({WORD_W{1'b1}} << off_reg) : {WORD_W{1'b1}};
        valid_mask = {WORD_W{1'b1}};
        if (addr_reg == '0)
        begin
            valid_mask[0] = 1'b0;
        end
        if (addr_reg == ADDR_W'(NUM_WORDS - 1))
        begin
            valid_mask[WORD_W-1] = 1'b0;
        end
        free_vec = ~mem_rdata_reg & start_mask & valid_mask;
        hit_idx  = first_set(free_vec);
        hit      = id_valid(gid_reg) && mem_rdata_reg[off_reg];
        cand     = id_valid(search_start_reg) ? search_start_reg[ID_WIDTH-1:0]
                                              : ID_WIDTH'(1);
    end

    always_comb
    begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        cnt_next          = cnt_reg;
        off_next          = off_reg;
        first_next        = first_reg;
        op_next           = op_reg;
        gid_next          = gid_reg;
        search_start_next = search_start_reg;
        done_next         = 1'b0;
        rsp_next          = rsp_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_addr          = addr_reg;
        mem_wdata         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.op;
                    gid_next = cmd.given_id;
                    mem_re   = 1'b1;
                    if (cmd.op == OP_ALLOC)
                    begin
                        addr_next  = cand[ID_WIDTH-1:WORD_BITS];
                        off_next   = cand[WORD_BITS-1:0];
                        first_next = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        addr_next  = cmd.given_id[ID_WIDTH-1:WORD_BITS];
                        off_next   = cmd.given_id[WORD_BITS-1:0];
                        state_next = ST_CHECK;
                    end
                    mem_addr = addr_next;
                end
            end
            ST_SCAN:
            begin
                if (free_vec != '0)
                begin
                    mem_we             = 1'b1;
                    mem_wdata          = mem_rdata_reg | (WORD_W'(1) << hit_idx);
                    rsp_next.status    = STATUS_OK;
                    rsp_next.result_id = FIELD_W'({addr_reg, hit_idx});
                    search_start_next  = FIELD_W'({addr_reg, hit_idx}) + FIELD_W'(1);
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else if (cnt_reg == CNT_W'(NUM_WORDS))
                begin
                    rsp_next.status    = STATUS_FULL;
                    rsp_next.result_id = '0;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    // wraps from the last word to word 0
                    addr_next  = addr_reg + ADDR_W'(1);
                    cnt_next   = cnt_reg + CNT_W'(1);
                    first_next = 1'b0;
                    mem_re     = 1'b1;
                    mem_addr   = addr_next;
                end
            end
            ST_CHECK:
            begin
                if (op_reg == OP_FREE && hit)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg & ~(WORD_W'(1) << off_reg);
                end
                rsp_next.status    = hit ? STATUS_OK : STATUS_NOT_IN_USE;
                rsp_next.result_id = gid_reg;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            addr_reg         <= '0;
            cnt_reg          <= '0;
            first_reg        <= 1'b0;
            search_start_reg <= FIELD_W'(1);
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            cnt_reg          <= cnt_next;
            first_reg        <= first_next;
            search_start_reg <= search_start_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        op_reg  <= op_next;
        gid_reg <= gid_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SCAN || state_reg == ST_CHECK))
        else $error("done without a finished command");

    a_full_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_FULL) |-> (rsp.result_id == '0))
        else $error("full result carries a nonzero id");

    a_alloc_id_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(state_reg == ST_SCAN) && rsp.status == STATUS_OK)
            |-> id_valid(rsp.result_id))
        else $error("allocated id out of range");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(NUM_WORDS)))
        else $error("scan ran past the whole map");

    a_pointer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        search_start_reg != '0)
        else $error("search pointer is zero");

endmodule

`default_nettype wire

// File: dv/nfhia_checker.sv
`timescale 1ns / 1ps

module nfhia_checker
    import nfhia_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  cmd_t      cmd,
    input  wire logic done,
    input  rsp_t      rsp,
    output int        mismatch_cnt,
    output int        rsp_owed
);

    localparam int TOP_ID = ALL_ONES_ID - 1;

    bit                 id_used [0:ALL_ONES_ID];
    logic [FIELD_W-1:0] scan_ptr;
    rsp_t               rsp_due [$];
    int                 n_bad;

    function automatic bit live_id(input logic [FIELD_W-1:0] id);
        return (id != '0) && (int'(id) < ALL_ONES_ID);
    endfunction

    function automatic rsp_t compute_rsp(input cmd_t c);
        rsp_t r;
        int   cand;
        bit   hit;
        r.status    = STATUS_OK;
        r.result_id = c.given_id;
        hit         = 1'b0;
        case (c.op)
            OP_ALLOC:
            begin
                cand = live_id(scan_ptr) ? int'(scan_ptr) : 1;
                for (int n = 0; n < TOP_ID; n++)
                begin
                    if (!id_used[cand])
                    begin
                        hit = 1'b1;
                        break;
                    end
                    cand++;
                    if (cand >= ALL_ONES_ID)
                    begin
                        cand = 1;
                    end
                end
                if (hit)
                begin
                    id_used[cand] = 1'b1;
                    r.result_id   = FIELD_W'(cand);
                    scan_ptr      = FIELD_W'(cand + 1);
                end
                else
                begin
                    r.status    = STATUS_FULL;
                    r.result_id = '0;
                end
            end
            OP_FREE:
            begin
                if (live_id(c.given_id) && id_used[c.given_id])
                begin
                    id_used[c.given_id] = 1'b0;
                end
                else
                begin
                    r.status = STATUS_NOT_IN_USE;
                end
            end
            default:
            begin
                // query; the spare op code behaves the same
                if (!(live_id(c.given_id) && id_used[c.given_id]))
                begin
                    r.status = STATUS_NOT_IN_USE;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i <= ALL_ONES_ID; i++)
            begin
                id_used[i] = 1'b0;
            end
            scan_ptr = FIELD_W'(1);
            rsp_due.delete();
            n_bad = 0;
        end
        else
        begin
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: expected none, actual status %0d id %0d",
                             $time, rsp.status, rsp.result_id);
                    n_bad++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                        n_bad++;
                    end
                    if (rsp.result_id !== want.result_id)
                    begin
                        $display("%0t: result_id mismatch: expected %0d, actual %0d",
                                 $time, want.result_id, rsp.result_id);
                        n_bad++;
                    end
                end
            end
            if (start && !busy)
            begin
                rsp_due.push_back(compute_rsp(cmd));
            end
        end
        mismatch_cnt <= n_bad;
        rsp_owed     <= rsp_due.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import nfhia_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int TOP_ID       = ALL_ONES_ID - 1;
    localparam int RAND_ITEMS   = 1500;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 4 * (RAND_ITEMS + 64) * (NUM_WORDS + 16);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    cmd_t cmd;
    rsp_t rsp;
    int   mismatch_cnt;
    int   rsp_owed;
    int   cycle_cnt = 0;

    next_fit_handle_id_allocator_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    nfhia_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .rsp          (rsp),
        .mismatch_cnt (mismatch_cnt),
        .rsp_owed     (rsp_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // holds the command until busy is low at an edge
    task automatic send_cmd(input logic [1:0] op, input logic [FIELD_W-1:0] id);
        cmd_t c;
        c.op       = op;
        c.given_id = id;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pause_cmds(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n)
            begin
                cmd <= cmd_t'($urandom);
                @(posedge clk);
            end
        end
    endtask

    // ids cluster around the recent allocation front
    function automatic cmd_t rand_cmd(input int alloc_cnt);
        cmd_t c;
        int   sel;
        int   hi;
        int   lo;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            c.op = OP_ALLOC;
        end
        else if (sel < 72)
        begin
            c.op = OP_FREE;
        end
        else if (sel < 95)
        begin
            c.op = OP_QUERY;
        end
        else
        begin
            c.op = OP_SPARE;
        end
        sel = $urandom_range(99);
        hi  = alloc_cnt + 7;
        lo  = (hi > 72) ? hi - 72 : 0;
        if (sel < 70)
        begin
            c.given_id = FIELD_W'($urandom_range(hi, lo));
        end
        else if (sel < 80)
        begin
            case ($urandom_range(5))
                0:       c.given_id = '0;
                1:       c.given_id = FIELD_W'(1);
                2:       c.given_id = FIELD_W'(TOP_ID);
                3:       c.given_id = FIELD_W'(ALL_ONES_ID);
                4:       c.given_id = 16'h8000;
                default: c.given_id = 16'h7fff;
            endcase
        end
        else
        begin
            c.given_id = FIELD_W'($urandom);
        end
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        int   sent;
        int   burst;
        int   gap;
        int   alloc_cnt;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_QUERY, FIELD_W'(1));
        send_cmd(OP_ALLOC, 16'hffff);
        send_cmd(OP_FREE, '0);
        send_cmd(OP_FREE, FIELD_W'(ALL_ONES_ID));
        send_cmd(OP_QUERY, '0);
        send_cmd(OP_QUERY, FIELD_W'(ALL_ONES_ID));
        send_cmd(OP_SPARE, FIELD_W'(2));
        send_cmd(OP_FREE, FIELD_W'(1));
        send_cmd(OP_FREE, FIELD_W'(1));
        send_cmd(OP_QUERY, FIELD_W'(1));
        send_cmd(OP_FREE, FIELD_W'(2));
        send_cmd(OP_QUERY, FIELD_W'(3));

        send_cmd(OP_QUERY, FIELD_W'(TOP_ID));
        send_cmd(OP_FREE, FIELD_W'(TOP_ID));
        send_cmd(OP_FREE, FIELD_W'(1));
        send_cmd(OP_FREE, FIELD_W'(40000));
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_ALLOC, '0);

        sent      = 0;
        alloc_cnt = 0;
        while (sent < RAND_ITEMS)
        begin
            burst = $urandom_range(16, 1);
            gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(7, 1);
            for (int k = 0; k < burst && sent < RAND_ITEMS; k++)
            begin
                c = rand_cmd(alloc_cnt);
                if (c.op == OP_ALLOC)
                begin
                    alloc_cnt++;
                end
                send_cmd(c.op, c.given_id);
                sent++;
            end
            pause_cmds(gap);
        end

        start <= 1'b0;
        @(posedge clk);
        while (rsp_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
